// ===== sv/mmcc_pkg.sv =====
// mmcc_pkg: shared types and constants for the magic multiplier collision check
// controller command and status structs, controller state encoding, register indexes
// no dependencies
package mmcc_pkg;

	localparam int DATA_WIDTH      = 64;
	localparam int HALF_WIDTH      = 32;
	localparam int SHIFT_WIDTH     = 6;
	localparam int CFG_INDEX_WIDTH = 1;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAGIC = 1'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHIFT = 1'd1;

	localparam logic [DATA_WIDTH-1:0]  MAGIC_RESET = 64'd1;
	localparam logic [SHIFT_WIDTH-1:0] SHIFT_RESET = 6'd63;

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_MUL   = 6'b000100,
		S_IDX   = 6'b001000,
		S_RD    = 6'b010000,
		S_WB    = 6'b100000
	} state_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic mul;
		logic idx;
		logic rd;
		logic wb;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
	} status_t;

endpackage

// ===== sv/mmcc_ctrl.sv =====
// mmcc_ctrl: controller state machine for the collision check
// sequences table clear, item load, multiply, index, table read and write back
// depends on mmcc_pkg
module mmcc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  mmcc_pkg::status_t status,
	output mmcc_pkg::cmd_t    cmd
);

	mmcc_pkg::state_t state_q;
	mmcc_pkg::state_t state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mmcc_pkg::S_CLEAR: begin
				if (status.clear_last) begin
					state_d = mmcc_pkg::S_IDLE;
				end
			end
			mmcc_pkg::S_IDLE: begin
				if (start) begin
					state_d = mmcc_pkg::S_MUL;
				end
			end
			mmcc_pkg::S_MUL: state_d = mmcc_pkg::S_IDX;
			mmcc_pkg::S_IDX: state_d = mmcc_pkg::S_RD;
			mmcc_pkg::S_RD:  state_d = mmcc_pkg::S_WB;
			mmcc_pkg::S_WB:  state_d = mmcc_pkg::S_IDLE;
			default:         state_d = mmcc_pkg::S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmcc_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy      = (state_q != mmcc_pkg::S_IDLE);
	assign cmd.clear = (state_q == mmcc_pkg::S_CLEAR);
	assign cmd.load  = (state_q == mmcc_pkg::S_IDLE) && start;
	assign cmd.mul   = (state_q == mmcc_pkg::S_MUL);
	assign cmd.idx   = (state_q == mmcc_pkg::S_IDX);
	assign cmd.rd    = (state_q == mmcc_pkg::S_RD);
	assign cmd.wb    = (state_q == mmcc_pkg::S_WB);

	// an accepted transaction always starts the multiply next
	a_load_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == mmcc_pkg::S_MUL))
		else $error("accepted item did not enter multiply");

	// write back closes the item and frees the block
	a_wb_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wb |=> !busy)
		else $error("block stayed busy after write back");

endmodule

// ===== sv/mmcc_datapath.sv =====
// mmcc_datapath: config registers, split 64-bit multiply, index shift, stamp and attack tables
// check generation, sticky failure flag and verdict output register
// depends on mmcc_pkg
module mmcc_datapath #(
	parameter int INDEX_BITS  = 12,
	parameter int STAMP_WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  mmcc_pkg::cmd_t                        cmd,
	output mmcc_pkg::status_t                     status,
	input  logic                                  cfg_we,
	input  logic [mmcc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [mmcc_pkg::DATA_WIDTH-1:0]       cfg_data,
	input  logic [mmcc_pkg::DATA_WIDTH-1:0]       occupancy,
	input  logic [mmcc_pkg::DATA_WIDTH-1:0]       attack_set,
	input  logic                                  last_entry,
	output logic                                  done,
	output logic                                  magic_valid
);

	localparam int DEPTH = 1 << INDEX_BITS;
	localparam int DW    = mmcc_pkg::DATA_WIDTH;
	localparam int HW    = mmcc_pkg::HALF_WIDTH;

	logic [DW-1:0]                    magic_q;
	logic [mmcc_pkg::SHIFT_WIDTH-1:0] shift_q;

	logic [DW-1:0] occ_q;
	logic [DW-1:0] atk_q;
	logic          last_q;

	logic [STAMP_WIDTH-1:0] gen_q;
	logic                   failed_q;
	logic                   open_q;

	logic [DW-1:0] pp_lo_q;
	logic [HW-1:0] pp_x1_q;
	logic [HW-1:0] pp_x2_q;
	logic [DW-1:0] x1_full;
	logic [DW-1:0] x2_full;
	logic [DW-1:0] product;
	logic [DW-1:0] shifted;
	logic [INDEX_BITS-1:0] slot_q;

	logic [INDEX_BITS-1:0] clr_cnt_q;

	logic [STAMP_WIDTH-1:0] stamp_mem [DEPTH];
	logic [DW-1:0]          atk_mem   [DEPTH];
	logic [STAMP_WIDTH-1:0] stamp_rd_q;
	logic [DW-1:0]          atk_rd_q;

	logic claim;
	logic conflict;
	logic failed_next;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= mmcc_pkg::MAGIC_RESET;
			shift_q <= mmcc_pkg::SHIFT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mmcc_pkg::REG_MAGIC: magic_q <= cfg_data;
				mmcc_pkg::REG_SHIFT: shift_q <= cfg_data[mmcc_pkg::SHIFT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			occ_q  <= occupancy;
			atk_q  <= attack_set;
			last_q <= last_entry;
		end
	end

	// low 64 bits of magic times occupancy from three 32x32 products
	assign x1_full = DW'(magic_q[HW-1:0]) * DW'(occ_q[DW-1:HW]);
	assign x2_full = DW'(magic_q[DW-1:HW]) * DW'(occ_q[HW-1:0]);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			pp_lo_q <= DW'(magic_q[HW-1:0]) * DW'(occ_q[HW-1:0]);
			pp_x1_q <= x1_full[HW-1:0];
			pp_x2_q <= x2_full[HW-1:0];
		end
	end

	assign product = pp_lo_q + {pp_x1_q + pp_x2_q, {HW{1'b0}}};
	assign shifted = product >> shift_q;

	always_ff @(posedge clk) begin
		if (cmd.idx) begin
			slot_q <= shifted[INDEX_BITS-1:0];
		end
	end

	// clear sweep counter for the stamp table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	assign status.clear_last = (clr_cnt_q == {INDEX_BITS{1'b1}});

	assign claim       = cmd.wb && !failed_q && (stamp_rd_q != gen_q);
	assign conflict    = cmd.wb && !failed_q && (stamp_rd_q == gen_q) && (atk_rd_q != atk_q);
	assign failed_next = failed_q || conflict;

	// stamp table
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			stamp_mem[clr_cnt_q] <= '0;
		end else if (claim) begin
			stamp_mem[slot_q] <= gen_q;
		end
		if (cmd.rd) begin
			stamp_rd_q <= stamp_mem[slot_q];
		end
	end

	// attack set table
	always_ff @(posedge clk) begin
		if (claim) begin
			atk_mem[slot_q] <= atk_q;
		end
		if (cmd.rd) begin
			atk_rd_q <= atk_mem[slot_q];
		end
	end

	// check generation and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q    <= '0;
			failed_q <= 1'b0;
			open_q   <= 1'b0;
		end else begin
			if (cmd.load && !open_q) begin
				gen_q    <= gen_q + 1'b1;
				failed_q <= 1'b0;
				open_q   <= 1'b1;
			end else if (cmd.wb) begin
				failed_q <= failed_next;
				if (last_q) begin
					open_q <= 1'b0;
				end
			end
		end
	end

	// verdict output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.wb && last_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wb) begin
			magic_valid <= !failed_next;
		end
	end

	// a verdict only follows the write back of a closing item
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(cmd.wb && last_q))
		else $error("verdict without closing item");

	// table claim and conflict never both happen
	a_claim_xor_conflict: assert property (@(posedge clk) disable iff (!arst_n)
		!(claim && conflict))
		else $error("claim and conflict together");

	// failure flag stays set within an open check
	a_failed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(failed_q && open_q) |=> failed_q)
		else $error("failure flag dropped inside a check");

endmodule

// ===== sv/magic_multiply_collision_check_core.sv =====
// magic_multiply_collision_check_core: top level of the magic multiplier collision check
// joins mmcc_ctrl and mmcc_datapath; depends on mmcc_pkg
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------------
//  item     | start, busy             | occupancy, attack_set, last_entry
//  verdict  | done (one-cycle strobe) | magic_valid
//  config   | cfg_valid, cfg_ready    | cfg_index, cfg_data
//
// after the accept cycle an item passes through partial products, product and index, table read
// and write back, each a registered state, before the next item can be accepted
// the verdict strobes in the cycle after the write back of the item with last_entry set
// after reset the stamp table is cleared entry by entry with busy high
// the receiver cannot stall; config writes are taken only while idle (cfg_ready is !busy)
module magic_multiply_collision_check_core #(
	parameter int INDEX_BITS  = 12,
	parameter int STAMP_WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [mmcc_pkg::DATA_WIDTH-1:0]      occupancy,
	input  logic [mmcc_pkg::DATA_WIDTH-1:0]      attack_set,
	input  logic                                 last_entry,
	output logic                                 done,
	output logic                                 magic_valid,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mmcc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [mmcc_pkg::DATA_WIDTH-1:0]      cfg_data
);

	mmcc_pkg::cmd_t    cmd;
	mmcc_pkg::status_t status;

	assign cfg_ready = !busy;

	mmcc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	mmcc_datapath #(
		.INDEX_BITS  (INDEX_BITS),
		.STAMP_WIDTH (STAMP_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.occupancy   (occupancy),
		.attack_set  (attack_set),
		.last_entry  (last_entry),
		.done        (done),
		.magic_valid (magic_valid)
	);

endmodule
